// File: hdl/telnet_iac_line_assembler_unit_assert.svh
// Assertion macros for the line assembler, included by the line counter module.
`ifndef TELNET_IAC_LINE_ASSEMBLER_UNIT_ASSERT_SVH
`define TELNET_IAC_LINE_ASSEMBLER_UNIT_ASSERT_SVH

// Same-cycle implication, clocked on clk and disabled during reset.
`define TIAU_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, clocked on clk and disabled during reset.
`define TIAU_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: hdl/tiau_pkg.sv
// Types and constants shared by the line assembler modules.
`default_nettype none
package tiau_pkg;

	localparam int LENGTH_BITS = 16;
	localparam int QDEPTH = 4;
	localparam int QAW = $clog2(QDEPTH);

	localparam logic [7:0] B_IAC  = 8'hFF;
	localparam logic [7:0] B_SB   = 8'hFA;
	localparam logic [7:0] B_SE   = 8'hF0;
	localparam logic [7:0] B_WILL = 8'hFB;
	localparam logic [7:0] B_WONT = 8'hFC;
	localparam logic [7:0] B_DO   = 8'hFD;
	localparam logic [7:0] B_DONT = 8'hFE;
	localparam logic [7:0] B_CR   = 8'h0D;
	localparam logic [7:0] B_LF   = 8'h0A;

	localparam logic [15:0] CAP_RESET = 16'd255;

	typedef enum logic [1:0] {
		OP_DATA    = 2'd0,
		OP_EOL     = 2'd1,
		OP_RESTART = 2'd2
	} op_t;

	typedef struct packed {
		op_t        op;
		logic [7:0] data;
	} op_item_t;

	typedef enum logic [4:0] {
		M_NORMAL  = 5'b00001,
		M_IAC     = 5'b00010,
		M_OPTION  = 5'b00100,
		M_SUB     = 5'b01000,
		M_SUB_IAC = 5'b10000
	} mode_t;

endpackage
`default_nettype wire

// File: hdl/tiau_queue.sv
// Short queue of classified words between the parser and the line counter.
`default_nettype none
module tiau_queue (
	input  wire                logic clk,
	input  wire                logic arst_n,
	input  wire                logic wr_en,
	input  wire tiau_pkg::op_item_t wr_item,
	output logic               full,
	input  wire                logic rd_en,
	output tiau_pkg::op_item_t rd_item,
	output logic               empty
);
	import tiau_pkg::*;

	op_item_t         mem_q [QDEPTH];
	logic [QAW-1:0]   wptr_q;
	logic [QAW-1:0]   rptr_q;
	logic [QAW:0]     cnt_q;
	logic             do_wr;
	logic             do_rd;

	assign full  = (cnt_q == (QAW+1)'(QDEPTH));
	assign empty = (cnt_q == '0);
	assign do_wr = wr_en && !full;
	assign do_rd = rd_en && !empty;
	assign rd_item = mem_q[rptr_q];

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wptr_q] <= wr_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (do_wr) begin
				wptr_q <= wptr_q + 1'b1;
			end
			if (do_rd) begin
				rptr_q <= rptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule
`default_nettype wire

// File: hdl/tiau_front.sv
// Telnet command parser that classifies each received word.
`default_nettype none
module tiau_front (
	input  wire                logic clk,
	input  wire                logic arst_n,
	input  wire                logic accept,
	input  wire                logic kind,
	input  wire                logic [7:0] rx_byte,
	output logic               q_wr,
	output tiau_pkg::op_item_t q_item
);
	import tiau_pkg::*;

	mode_t mode_q;
	mode_t mode_d;
	logic  emit;
	op_t   op;
	logic [7:0] data;

	always_comb begin
		mode_d = mode_q;
		emit   = 1'b0;
		op     = OP_DATA;
		data   = rx_byte;
		if (kind) begin
			mode_d = M_NORMAL;
			emit   = 1'b1;
			op     = OP_RESTART;
		end else begin
			case (mode_q)
				M_IAC: begin
					mode_d = M_NORMAL;
					if (rx_byte == B_IAC) begin
						emit = 1'b1;
					end else if (rx_byte == B_SB) begin
						mode_d = M_SUB;
					end else if (rx_byte inside {B_WILL, B_WONT, B_DO, B_DONT}) begin
						mode_d = M_OPTION;
					end
				end
				M_OPTION: mode_d = M_NORMAL;
				M_SUB: begin
					if (rx_byte == B_IAC) begin
						mode_d = M_SUB_IAC;
					end
				end
				M_SUB_IAC: begin
					// A doubled IAC keeps waiting for SE with the second IAC.
					if (rx_byte == B_SE) begin
						mode_d = M_NORMAL;
					end else if (rx_byte != B_IAC) begin
						mode_d = M_SUB;
					end
				end
				default: begin
					mode_d = M_NORMAL;
					if (rx_byte == B_IAC) begin
						mode_d = M_IAC;
					end else if (rx_byte == B_LF) begin
						emit = 1'b1;
						op   = OP_EOL;
					end else if (rx_byte != B_CR) begin
						emit = 1'b1;
					end
				end
			endcase
		end
	end

	assign q_wr   = accept && emit;
	assign q_item = '{op: op, data: data};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= M_NORMAL;
		end else if (accept) begin
			mode_q <= mode_d;
		end
	end

endmodule
`default_nettype wire

// File: hdl/tiau_back.sv
// Line counter and result register that carries out classified words.
`default_nettype none
module tiau_back (
	input  wire                logic clk,
	input  wire                logic arst_n,
	input  wire                logic cfg_we,
	input  wire                logic [15:0] cfg_wdata,
	input  wire                logic q_empty,
	input  wire tiau_pkg::op_item_t q_item,
	output logic               q_rd,
	input  wire                logic pop,
	output logic               empty,
	output logic [7:0]         data_byte,
	output logic               end_of_line,
	output logic [15:0]        line_length,
	output logic               line_truncated
);
	import tiau_pkg::*;

	logic [15:0]            cap_q;
	logic [LENGTH_BITS-1:0] cnt_q;
	logic                   ovf_q;
	logic                   out_valid_q;
	logic [7:0]             out_data_q;
	logic                   out_eol_q;
	logic [15:0]            out_len_q;
	logic                   out_trunc_q;
	logic                   out_ready;
	logic                   work;
	logic                   room;
	logic                   produce;

	assign out_ready = !out_valid_q || pop;
	assign work      = !q_empty && out_ready;
	assign q_rd      = work;
	// A full counter also stops the line, which clamps a capacity the count cannot reach.
	assign room      = (cnt_q != '1) && (cnt_q < cap_q);
	assign produce   = work && ((q_item.op == OP_DATA && room) || q_item.op == OP_EOL);

	assign empty          = !out_valid_q;
	assign data_byte      = out_data_q;
	assign end_of_line    = out_eol_q;
	assign line_length    = out_len_q;
	assign line_truncated = out_trunc_q;

	always_ff @(posedge clk) begin
		if (work) begin
			if (q_item.op == OP_EOL) begin
				out_data_q  <= '0;
				out_eol_q   <= 1'b1;
				out_len_q   <= 16'(cnt_q);
				out_trunc_q <= ovf_q;
			end else begin
				out_data_q  <= q_item.data;
				out_eol_q   <= 1'b0;
				out_len_q   <= '0;
				out_trunc_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q       <= CAP_RESET;
			cnt_q       <= '0;
			ovf_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				cap_q <= cfg_wdata;
			end
			if (produce) begin
				out_valid_q <= 1'b1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
			if (work) begin
				case (q_item.op)
					OP_DATA: begin
						if (room) begin
							cnt_q <= cnt_q + 1'b1;
						end else begin
							ovf_q <= 1'b1;
						end
					end
					OP_EOL: begin
						cnt_q <= '0;
						ovf_q <= 1'b0;
					end
					default: begin
						cnt_q <= '0;
						ovf_q <= 1'b0;
					end
				endcase
			end
		end
	end

	`include "telnet_iac_line_assembler_unit_assert.svh"

	`TIAU_ASSERT_NOW(a_data_fields_clear, out_valid_q && !out_eol_q,
		out_len_q == '0 && !out_trunc_q, "data word carries line status")
	`TIAU_ASSERT_NEXT(a_eol_clears_line, work && q_item.op == OP_EOL,
		cnt_q == '0 && !ovf_q, "line state not cleared after end of line")
	`TIAU_ASSERT_NEXT(a_restart_clears, work && q_item.op == OP_RESTART,
		cnt_q == '0 && !ovf_q && !out_valid_q, "restart left line state")
	`TIAU_ASSERT_NEXT(a_drop_sets_flag, work && q_item.op == OP_DATA && !room,
		ovf_q && $stable(cnt_q), "dropped byte did not set truncation")

endmodule
`default_nettype wire

// File: hdl/telnet_iac_line_assembler_unit.sv
// Top level of the Telnet receive line assembler with IAC filtering.
//
//  channel  | handshake        | fields
//  ---------+------------------+-----------------------------------------------
//  input    | push / full      | kind, rx_byte
//  result   | empty / pop      | data_byte, end_of_line, line_length, line_truncated
//  config   | cfg_we           | cfg_wdata (line_capacity)
//
// One input word per cycle while full is low; a word that yields a result passes through
// the queue and then the result register. The parser, a four-word queue and the line
// counter each take one word per cycle, the counter only while the result is not stalled.
// Reset clears parser mode, queue, line count and flag; capacity returns to 255. A stalled
// result holds the counter; the queue absorbs up to four words before full rises.
`default_nettype none
module telnet_iac_line_assembler_unit (
	input  wire  logic        clk,
	input  wire  logic        arst_n,
	input  wire  logic        push,
	output logic              full,
	input  wire  logic        kind,
	input  wire  logic [7:0]  rx_byte,
	output logic              empty,
	input  wire  logic        pop,
	output logic [7:0]        data_byte,
	output logic              end_of_line,
	output logic [15:0]       line_length,
	output logic              line_truncated,
	input  wire  logic        cfg_we,
	input  wire  logic [15:0] cfg_wdata
);
	import tiau_pkg::*;

	logic     accept;
	logic     q_wr;
	logic     q_rd;
	logic     q_empty;
	op_item_t q_wr_item;
	op_item_t q_rd_item;

	assign accept = push && !full;

	tiau_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.accept  (accept),
		.kind    (kind),
		.rx_byte (rx_byte),
		.q_wr    (q_wr),
		.q_item  (q_wr_item)
	);

	tiau_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (q_wr),
		.wr_item (q_wr_item),
		.full    (full),
		.rd_en   (q_rd),
		.rd_item (q_rd_item),
		.empty   (q_empty)
	);

	tiau_back u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_wdata      (cfg_wdata),
		.q_empty        (q_empty),
		.q_item         (q_rd_item),
		.q_rd           (q_rd),
		.pop            (pop),
		.empty          (empty),
		.data_byte      (data_byte),
		.end_of_line    (end_of_line),
		.line_length    (line_length),
		.line_truncated (line_truncated)
	);

endmodule
`default_nettype wire
